// ===== hdl/fpd_pkg.sv =====
`timescale 1ns / 1ps

package fpd_pkg;

  localparam int PAYLOAD_BYTES = 16;
  // count of payload bytes taken, wide enough to hold PAYLOAD_BYTES itself
  localparam int IDX_W = $clog2(PAYLOAD_BYTES + 1);

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_START_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_SECOND = CFG_IDX_W'(1);

  typedef struct packed {
    logic       payload_valid;
    logic [3:0] payload_index;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic       frame_ok;
  } result_t;

endpackage

// ===== hdl/fpd_in_stage.sv =====
`timescale 1ns / 1ps

module fpd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  output logic       in_valid,
  output logic [7:0] in_byte,
  input  logic       take
);
  import fpd_pkg::*;

  logic       valid;
  logic [7:0] rx_byte;

  // register empties as the core takes the word, so a new one can land each cycle while the core keeps taking
  assign s_axis_tready = !valid || take;
  assign in_valid      = valid;
  assign in_byte       = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      rx_byte <= s_axis_tdata;
    end
  end

endmodule

// ===== hdl/fpd_core.sv =====
`timescale 1ns / 1ps

module fpd_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [7:0]                in_byte,
  output logic                      take,
  input  logic [7:0]                start_byte_first,
  input  logic [7:0]                start_byte_second,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fpd_pkg::result_t          result
);
  import fpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_DATA,
    PH_CHK1,
    PH_CHK2
  } phase_t;

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       sum_low, sum_low_next;
  logic [7:0]       sum_high, sum_high_next;
  result_t          result_next;
  logic [IDX_W-1:0] index_inc;
  logic [7:0]       low_add;

  assign take      = in_valid && (!out_valid || out_ready);
  assign index_inc = byte_index + IDX_W'(1);
  assign low_add   = sum_low + in_byte;

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    sum_low_next    = sum_low;
    sum_high_next   = sum_high;
    result_next     = '0;
    unique case (phase)
      PH_HUNT1: begin
        if (in_byte == start_byte_first) phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        // a mismatch here is not retried as a first start byte
        phase_next      = (in_byte == start_byte_second) ? PH_DATA : PH_HUNT1;
        byte_index_next = '0;
        sum_low_next    = '0;
        sum_high_next   = '0;
      end
      PH_DATA: begin
        result_next.payload_valid = 1'b1;
        result_next.payload_index = 4'(byte_index);
        result_next.payload_byte  = in_byte;
        sum_low_next    = low_add;
        sum_high_next   = sum_high + low_add;
        byte_index_next = index_inc;
        if (index_inc == IDX_W'(PAYLOAD_BYTES)) phase_next = PH_CHK1;
      end
      PH_CHK1: begin
        if (in_byte == sum_low) begin
          phase_next = PH_CHK2;
        end else begin
          phase_next             = PH_HUNT1;
          result_next.frame_done = 1'b1;
        end
      end
      PH_CHK2: begin
        phase_next             = PH_HUNT1;
        result_next.frame_done = 1'b1;
        result_next.frame_ok   = (in_byte == sum_high);
      end
      default: begin
        phase_next = PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT1;
      byte_index <= '0;
      sum_low    <= '0;
      sum_high   <= '0;
      out_valid  <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      sum_low    <= sum_low_next;
      sum_high   <= sum_high_next;
      out_valid  <= 1'b1;
    end else if (out_ready) begin
      out_valid  <= 1'b0;
    end
    if (take) begin
      result <= result_next;
    end
  end

endmodule

// ===== hdl/fletcher_packet_deframer_core.sv =====
`timescale 1ns / 1ps

// fletcher-16 checked packet deframer
// s_axis takes one received byte per word. the block hunts for the two
// configured start bytes, then passes PAYLOAD_BYTES payload bytes, each
// tagged with its position, and checks two fletcher check bytes against
// the running sums.
// m_axis gives exactly one word per input word: tdata carries payload index
// and byte, tuser flags a payload byte and a good frame, tlast marks frame
// end (pass or fail; a failed first check byte ends the frame at once).
// cfg writes set start_byte_first (index 0) and start_byte_second (index 1);
// other indexes are ignored. cfg_ready is always high; write only when idle.
// an accepted word is registered first in the input stage, then in the result
// register, and appears on m_axis from the result register.
// throughput: one word per cycle unless m_axis stalls, set by the single
// state update and the two 8-bit adds between input and result registers.
// reset clears the frame state, sums and both start bytes to zero.
// if the receiver stalls, the result register holds and an empty input
// stage takes one more word; s_axis_tready then drops until m_axis moves.

module fletcher_packet_deframer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [3:0] payload_index, [11:4] payload_byte
  output logic                           m_axis_tlast,  // frame_done
  output logic [1:0]                     m_axis_tuser,  // [0] payload_valid, [1] frame_ok
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import fpd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       take;
  logic [7:0] start_byte_first;
  logic [7:0] start_byte_second;
  result_t    result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte_first  <= '0;
      start_byte_second <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_START_FIRST)  start_byte_first  <= cfg_data;
      if (cfg_index == REG_START_SECOND) start_byte_second <= cfg_data;
    end
  end

  fpd_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .in_valid      (in_valid),
    .in_byte       (in_byte),
    .take          (take)
  );

  fpd_core u_core (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_byte           (in_byte),
    .take              (take),
    .start_byte_first  (start_byte_first),
    .start_byte_second (start_byte_second),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .result            (result)
  );

  assign m_axis_tdata = {4'b0000, result.payload_byte, result.payload_index};
  assign m_axis_tlast = result.frame_done;
  assign m_axis_tuser = {result.frame_ok, result.payload_valid};

`ifndef SYNTHESIS
  a_ok_ends_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("good frame flagged without frame end");

  a_payload_not_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast)
    else $error("payload word also marks frame end");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result word valid straight after reset");
`endif

endmodule

// ===== test/tb_fletcher_packet_deframer_core.sv =====
`timescale 1ns / 1ps

module tb_fletcher_packet_deframer_core;
  import fpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_PAYLOAD, CHECK_LOW, CHECK_HIGH
  } deframe_phase_t;

  typedef enum {FRAME_GOOD, FRAME_BAD_LOW, FRAME_BAD_HIGH} frame_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 m_axis_tlast;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // predictor state, equal to the reset state at time zero
  logic [7:0]     start_first = '0;
  logic [7:0]     start_second = '0;
  deframe_phase_t cur_phase = HUNT_FIRST;
  logic [7:0]     taken_count = '0;
  logic [7:0]     sum_lo = '0;
  logic [7:0]     sum_hi = '0;

  result_t expected_words[$];
  result_t want;
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      quiet_cycles = 0;
  int      hold_left = 0;
  bit      no_idle = 1'b0;

  fletcher_packet_deframer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (cur_phase)
      HUNT_FIRST: begin
        if (b == start_first) cur_phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        // sums are cleared whether or not the second start byte matches
        cur_phase = (b == start_second) ? TAKE_PAYLOAD : HUNT_FIRST;
        taken_count = '0;
        sum_lo = '0;
        sum_hi = '0;
      end
      TAKE_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_index = taken_count[3:0];
        r.payload_byte = b;
        sum_lo = sum_lo + b;
        sum_hi = sum_hi + sum_lo;
        taken_count = taken_count + 8'd1;
        if (taken_count >= PAYLOAD_BYTES) cur_phase = CHECK_LOW;
      end
      CHECK_LOW: begin
        if (b == sum_lo) begin
          cur_phase = CHECK_HIGH;
        end else begin
          cur_phase = HUNT_FIRST;
          r.frame_done = 1'b1;
        end
      end
      CHECK_HIGH: begin
        cur_phase = HUNT_FIRST;
        r.frame_done = 1'b1;
        r.frame_ok = (b == sum_hi);
      end
      default: cur_phase = HUNT_FIRST;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatch_count++;
    $display("mismatch on %s: got %0h, want %0h (word %0d)", what, got, exp_val,
             items_sent);
  endtask

  // input words are predicted before output words are checked, so one edge has one order
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) expected_words.push_back(deframe_byte(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing pending", int'(m_axis_tdata), 0);
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tuser[0] !== want.payload_valid)
            report_mismatch("payload_valid", int'(m_axis_tuser[0]),
                            int'(want.payload_valid));
          if (m_axis_tdata[3:0] !== want.payload_index)
            report_mismatch("payload_index", int'(m_axis_tdata[3:0]),
                            int'(want.payload_index));
          if (m_axis_tdata[11:4] !== want.payload_byte)
            report_mismatch("payload_byte", int'(m_axis_tdata[11:4]),
                            int'(want.payload_byte));
          if (m_axis_tlast !== want.frame_done)
            report_mismatch("frame_done", int'(m_axis_tlast), int'(want.frame_done));
          if (m_axis_tuser[1] !== want.frame_ok)
            report_mismatch("frame_ok", int'(m_axis_tuser[1]), int'(want.frame_ok));
        end
      end
    end
  end

  // receiver: random stalls, a counted hold-off on request, none in quiet stretches
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 15) gap = $urandom_range(3, 1);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0] p;
    logic [7:0] lo;
    logic [7:0] hi;
    lo = '0;
    hi = '0;
    send_byte(start_first);
    send_byte(start_second);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      p = 8'($urandom_range(255));
      lo = lo + p;
      hi = hi + lo;
      send_byte(p);
    end
    if (kind == FRAME_BAD_LOW) begin
      send_byte(lo ^ (8'd1 << $urandom_range(7)));
    end else begin
      send_byte(lo);
      send_byte((kind == FRAME_BAD_HIGH) ? hi ^ (8'd1 << $urandom_range(7)) : hi);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    int r;
    logic [7:0] b;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        r = $urandom_range(99);
        send_frame(r < 60 ? FRAME_GOOD : (r < 80 ? FRAME_BAD_LOW : FRAME_BAD_HIGH));
      end else if (r < 88) begin
        // broken start: a wrong second byte, often the first start byte again
        send_byte(start_first);
        if (start_first != start_second && $urandom_range(1)) begin
          send_byte(start_first);
        end else begin
          b = 8'($urandom_range(255));
          if (b == start_second) b = b + 8'd1;
          send_byte(b);
        end
      end else begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no second assignment
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_START_FIRST:  start_first = val;
      REG_START_SECOND: start_second = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] first, input logic [7:0] second);
    wait_drained();
    write_reg(REG_START_FIRST, first);
    write_reg(REG_START_SECOND, second);
    cfg_valid <= 1'b0;
  endtask

  // both start bytes still zero from reset
  task automatic test_reset_values();
    run_random(150);
  endtask

  task automatic test_frame_corner_cases();
    logic [7:0] p;
    logic [7:0] lo;
    logic [7:0] hi;
    configure(8'h7E, 8'h81);
    lo = '0;
    hi = '0;
    // repeated first start byte is a failed second byte, not a new first one
    send_byte(8'h7E);
    send_byte(8'h7E);
    send_byte(8'h81);
    send_byte(8'h7E);
    send_byte(8'h81);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      p = (i % 2 != 0) ? 8'hFF : 8'h00;
      lo = lo + p;
      hi = hi + lo;
      send_byte(p);
    end
    send_byte(lo);
    send_byte(~hi);
  endtask

  task automatic test_ignored_index();
    wait_drained();
    write_reg(REG_UNUSED_LOW, 8'($urandom_range(255)));
    write_reg(REG_UNUSED_TOP, 8'($urandom_range(255)));
    cfg_valid <= 1'b0;
    run_random(100);
  endtask

  task automatic test_start_settings();
    configure(8'hFF, 8'hFF);
    run_random(200);
    configure(8'h00, 8'hFF);
    no_idle = 1'b1;
    run_random(200);
    no_idle = 1'b0;
    configure(8'hFF, 8'h00);
    run_random(200);
    repeat (2) begin
      configure(8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random(200);
    end
  endtask

  task automatic test_backpressure();
    configure(8'hA5, 8'h5A);
    hold_left = HOLD_OFF_CYCLES;
    send_frame(FRAME_GOOD);
    send_frame(FRAME_BAD_HIGH);
    run_random(20);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_frame_corner_cases();
    test_ignored_index();
    test_start_settings();
    test_backpressure();
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
